### src/rdfta_pkg.sv
// Shared types, field widths and sine table generation for the running DFT accumulator.
`default_nettype none

package rdfta_pkg;

    // Default sizes
    localparam int NUM_POINTS_DEF      = 4096;
    localparam int NUM_FREQ_DEF        = 4;
    localparam int NUM_SHOTS_DEF       = 2;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Port widths
    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 1;
    localparam int SUM_W      = 48;
    localparam int OUT_DATA_W = 6 * SUM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_0     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_1     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_2     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_3     = 3'd7;

    // Request kinds
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_TRIG,
        ST_WRITE,
        ST_READ,
        ST_RESP
    } state_t;

    // Multiply operations of the shared unit
    typedef enum logic [3:0] {
        OP_T,   // step * dt
        OP_W,   // dt * decimation
        OP_P0,  // t[31:0] * f[15:0]
        OP_P1,  // t[31:0] * f[31:16]
        OP_P2,  // t[47:32] * f[15:0]
        OP_C0,  // cos * w[31:0]
        OP_C1,  // cos * w[47:32]
        OP_S0,  // sin * w[31:0]
        OP_S1,  // sin * w[47:32]
        OP_VL,  // sample * weight[23:0]
        OP_VH   // sample * weight[40:24]
    } op_t;

    // Quarter-wave polynomial coefficients, Q30
    localparam longint unsigned C1 = 64'd1686629713;
    localparam longint unsigned C3 = 64'd693598668;
    localparam longint unsigned C5 = 64'd85569306;
    localparam longint unsigned C7 = 64'd5026995;
    localparam longint unsigned C9 = 64'd172272;

    // sin(pi/2 * q/Q) in Q1.15, Horner with truncating steps
    function automatic logic signed [15:0] quarter_sine(int bits, int q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned r;
        x  = longint'(q) << (32 - bits);
        x2 = (x * x) >> 30;
        p  = C9;
        p  = C7 - ((x2 * p) >> 30);
        p  = C5 - ((x2 * p) >> 30);
        p  = C3 - ((x2 * p) >> 30);
        p  = C1 - ((x2 * p) >> 30);
        r  = (((x * p) >> 30) + 64'd16384) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return 16'(r);
    endfunction

    // Full-wave table entry by quadrant symmetry
    function automatic logic signed [15:0] sine_entry(int bits, int k);
        int qn;
        int quad;
        int r;
        logic signed [15:0] v;
        qn   = 1 << (bits - 2);
        quad = k >> (bits - 2);
        r    = k & (qn - 1);
        case (quad)
            0:       v = quarter_sine(bits, r);
            1:       v = quarter_sine(bits, qn - r);
            2:       v = -quarter_sine(bits, r);
            default: v = -quarter_sine(bits, qn - r);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/rdfta_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none

module rdfta_mul (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic signed [rdfta_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [rdfta_pkg::MUL_B_W-1:0] b,
    output logic signed      [rdfta_pkg::MUL_P_W-1:0] prod
);
    import rdfta_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    // One product per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### src/running_dft_accumulator.sv
// Top level of the running DFT accumulator: sequencer, accumulator store and ports.
`default_nettype none

// Running DFT accumulator. An accumulate request (tuser 0) forms the sample time,
// then for each active frequency the phase, cosine and sine weights and six
// saturating 48-bit sums, all through one shared 33x25 multiplier run by a small
// sequencer. For each active frequency an accumulate runs 19 multiplies, one table
// lookup and one read-modify-write of the 288-bit accumulator word; one that is
// out of range or has no active frequency is dropped and the sequencer stays idle.
// A read request (tuser 1) reads one point's six sums for the chosen frequency
// from the store, zeros when out of range, and loads them into the result
// register once it is free; it waits while an earlier result is still held.
// After reset the store is cleared one word a cycle through all of its
// NUM_SHOTS*NUM_FREQ*NUM_POINTS words (32768 by default), during which no
// request is taken. Configuration registers are only to be written while no
// request is in progress.
module running_dft_accumulator #(
    parameter int NUM_POINTS      = rdfta_pkg::NUM_POINTS_DEF,
    parameter int NUM_FREQ        = rdfta_pkg::NUM_FREQ_DEF,
    parameter int NUM_SHOTS       = rdfta_pkg::NUM_SHOTS_DEF,
    parameter int SINE_TABLE_BITS = rdfta_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Request channel
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // time_step[19:0], backward[20], shot_slot[21], point_index[33:22],
    // freq_select[35:34], vel_x[59:36], vel_y[83:60], vel_z[107:84], zero fill
    input  wire logic [rdfta_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type[0]
    input  wire logic [rdfta_pkg::IN_USER_W-1:0]      s_tuser,
    // Result channel
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // real_x[47:0], real_y[95:48], real_z[143:96],
    // imag_x[191:144], imag_y[239:192], imag_z[287:240]
    output logic [rdfta_pkg::OUT_DATA_W-1:0]          m_tdata,
    // Configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [rdfta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rdfta_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rdfta_pkg::*;

    localparam int DEPTH       = NUM_SHOTS * NUM_FREQ * NUM_POINTS;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SHOT_STRIDE = NUM_FREQ * NUM_POINTS;
    localparam int FI_W        = (NUM_FREQ > 1) ? $clog2(NUM_FREQ) : 1;
    localparam int TAB_SIZE    = 1 << SINE_TABLE_BITS;
    localparam logic [SINE_TABLE_BITS-1:0] QUARTER = SINE_TABLE_BITS'(TAB_SIZE / 4);

    // Constant sine table
    typedef logic signed [15:0] sine_tab_t [TAB_SIZE];

    function automatic sine_tab_t build_tab();
        sine_tab_t tab;
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            tab[k] = sine_entry(SINE_TABLE_BITS, k);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_tab();

    // Request fields
    logic                 in_req;
    logic [19:0]          in_step;
    logic                 in_back;
    logic                 in_shot;
    logic [11:0]          in_pt;
    logic [1:0]           in_fs;
    logic signed [23:0]   in_vx;
    logic signed [23:0]   in_vy;
    logic signed [23:0]   in_vz;

    assign in_req  = s_tuser[0];
    assign in_step = s_tdata[19:0];
    assign in_back = s_tdata[20];
    assign in_shot = s_tdata[21];
    assign in_pt   = s_tdata[33:22];
    assign in_fs   = s_tdata[35:34];
    assign in_vx   = $signed(s_tdata[59:36]);
    assign in_vy   = $signed(s_tdata[83:60]);
    assign in_vz   = $signed(s_tdata[107:84]);

    // Configuration registers
    logic [31:0] dt_reg;
    logic [47:0] ttime_reg;
    logic [15:0] dec_reg;
    logic [2:0]  nfreq_reg;
    logic [31:0] freq_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg      <= 32'd4294967;
            ttime_reg   <= 48'h1_0000_0000;
            dec_reg     <= 16'd1;
            nfreq_reg   <= 3'd4;
            freq_reg[0] <= '0;
            freq_reg[1] <= '0;
            freq_reg[2] <= '0;
            freq_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DT:         dt_reg      <= cfg_wdata[31:0];
                REG_TOTAL_TIME: ttime_reg   <= cfg_wdata[47:0];
                REG_DECIMATION: dec_reg     <= cfg_wdata[15:0];
                REG_ACTIVE:     nfreq_reg   <= cfg_wdata[2:0];
                REG_FREQ_0:     freq_reg[0] <= cfg_wdata[31:0];
                REG_FREQ_1:     freq_reg[1] <= cfg_wdata[31:0];
                REG_FREQ_2:     freq_reg[2] <= cfg_wdata[31:0];
                REG_FREQ_3:     freq_reg[3] <= cfg_wdata[31:0];
                default:        ;
            endcase
        end
    end

    // Control state
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [2:0]        j_reg, j_next;
    logic [FI_W-1:0]   l_reg, l_next;
    logic [2:0]        nf_reg;
    logic              ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              m_tvalid_reg;

    // Datapath registers
    logic [19:0]                 step_reg;
    logic                        back_reg;
    logic signed [23:0]          v_reg [3];
    logic [47:0]                 t_reg;
    logic [47:0]                 w_reg;
    logic [47:0]                 ph_reg;
    logic signed [15:0]          sn_reg;
    logic signed [15:0]          cs_reg;
    logic signed [63:0]          acc_reg;
    logic signed [40:0]          wc_reg;
    logic signed [40:0]          ws_reg;
    logic signed [55:0]          inc_reg [6];
    logic [OUT_DATA_W-1:0]       rdata_reg;
    logic [OUT_DATA_W-1:0]       m_tdata_reg;

    // Capture decode
    logic              s_accept;
    logic              in_loc_ok;
    logic              in_fs_ok;
    logic [2:0]        in_nf;
    logic [ADDR_W-1:0] in_addr;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_loc_ok = (32'(in_shot) < 32'(NUM_SHOTS)) && (32'(in_pt) < 32'(NUM_POINTS));
    assign in_fs_ok  = (32'(in_fs) < 32'(NUM_FREQ));
    assign in_nf     = (nfreq_reg > 3'(NUM_FREQ)) ? 3'(NUM_FREQ) : nfreq_reg;
    assign in_addr   = ADDR_W'(32'(in_shot) * 32'(SHOT_STRIDE)
                       + ((in_req == REQ_READ) ? 32'(in_fs) * 32'(NUM_POINTS) : 32'd0)
                       + 32'(in_pt));

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        j_next     = j_reg;
        l_next     = l_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_req == REQ_READ)
                        state_next = ST_READ;
                    else if (in_loc_ok && (in_nf != 3'd0))
                    begin
                        state_next = ST_MUL;
                        op_next    = OP_T;
                        l_next     = '0;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                state_next = ST_MUL;
                case (op_reg)
                    OP_T:  op_next = OP_W;
                    OP_W:  op_next = OP_P0;
                    OP_P0: op_next = OP_P1;
                    OP_P1: op_next = OP_P2;
                    OP_P2: state_next = ST_TRIG;
                    OP_C0: op_next = OP_C1;
                    OP_C1: op_next = OP_S0;
                    OP_S0: op_next = OP_S1;
                    OP_S1:
                    begin
                        op_next = OP_VL;
                        j_next  = 3'd0;
                    end
                    OP_VL: op_next = OP_VH;
                    OP_VH:
                    begin
                        if (j_reg == 3'd5)
                            state_next = ST_WRITE;
                        else
                        begin
                            j_next  = j_reg + 3'd1;
                            op_next = OP_VL;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_TRIG:
            begin
                state_next = ST_MUL;
                op_next    = OP_C0;
            end
            ST_WRITE:
            begin
                if ((3'(l_reg) + 3'd1) == nf_reg)
                    state_next = ST_IDLE;
                else
                begin
                    l_next     = l_reg + 1'b1;
                    op_next    = OP_P0;
                    state_next = ST_MUL;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            op_reg       <= OP_T;
            j_reg        <= '0;
            l_reg        <= '0;
            nf_reg       <= '0;
            ok_reg       <= 1'b0;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            j_reg     <= j_next;
            l_reg     <= l_next;
            if (state_reg == ST_CLEAR)
                addr_reg <= addr_reg + 1'b1;
            else if (s_accept)
            begin
                addr_reg <= in_addr;
                nf_reg   <= in_nf;
                ok_reg   <= in_loc_ok && ((in_req == REQ_ACCUM) || in_fs_ok);
            end
            else if ((state_reg == ST_WRITE) && (state_next == ST_MUL))
                addr_reg <= addr_reg + ADDR_W'(NUM_POINTS);

            // result register: a load wins over the hand-off
            if ((state_reg == ST_RESP) && (state_next == ST_IDLE))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Shared multiplier operand selection
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic [31:0]               cur_freq;
    logic signed [23:0]        cur_v;
    logic signed [40:0]        cur_wt;

    assign cur_freq = freq_reg[2'(l_reg)];

    always_comb
    begin
        case (j_reg)
            3'd0, 3'd3: cur_v = v_reg[0];
            3'd1, 3'd4: cur_v = v_reg[1];
            default:    cur_v = v_reg[2];
        endcase
        cur_wt = (j_reg < 3'd3) ? wc_reg : ws_reg;
    end

    always_comb
    begin
        case (op_reg)
            OP_T:
            begin
                mul_a = {1'b0, dt_reg};
                mul_b = {5'b0, step_reg};
            end
            OP_W:
            begin
                mul_a = {1'b0, dt_reg};
                mul_b = {9'b0, dec_reg};
            end
            OP_P0:
            begin
                mul_a = {1'b0, t_reg[31:0]};
                mul_b = {9'b0, cur_freq[15:0]};
            end
            OP_P1:
            begin
                mul_a = {1'b0, t_reg[31:0]};
                mul_b = {9'b0, cur_freq[31:16]};
            end
            OP_P2:
            begin
                mul_a = {17'b0, t_reg[47:32]};
                mul_b = {9'b0, cur_freq[15:0]};
            end
            OP_C0:
            begin
                mul_a = {1'b0, w_reg[31:0]};
                mul_b = {{9{cs_reg[15]}}, cs_reg};
            end
            OP_C1:
            begin
                mul_a = {17'b0, w_reg[47:32]};
                mul_b = {{9{cs_reg[15]}}, cs_reg};
            end
            OP_S0:
            begin
                mul_a = {1'b0, w_reg[31:0]};
                mul_b = {{9{sn_reg[15]}}, sn_reg};
            end
            OP_S1:
            begin
                mul_a = {17'b0, w_reg[47:32]};
                mul_b = {{9{sn_reg[15]}}, sn_reg};
            end
            OP_VL:
            begin
                mul_a = {9'b0, cur_wt[23:0]};
                mul_b = {cur_v[23], cur_v};
            end
            OP_VH:
            begin
                mul_a = {{16{cur_wt[40]}}, cur_wt[40:24]};
                mul_b = {cur_v[23], cur_v};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rdfta_mul u_mul (
        .clk  (clk),
        .en   (state_reg == ST_MUL),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Fold terms
    logic signed [63:0] prod64;
    logic signed [63:0] fold_c;
    logic signed [63:0] fold_v;
    logic [SINE_TABLE_BITS-1:0] ph_idx;

    assign prod64 = {{(64 - MUL_P_W){prod[MUL_P_W-1]}}, prod};
    assign fold_c = acc_reg + (prod64 <<< 32);
    assign fold_v = acc_reg + (prod64 <<< 24);
    assign ph_idx = ph_reg[47 -: SINE_TABLE_BITS];

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            step_reg <= in_step;
            back_reg <= in_back;
            v_reg[0] <= in_vx;
            v_reg[1] <= in_vy;
            v_reg[2] <= in_vz;
        end
        if (state_reg == ST_TRIG)
        begin
            sn_reg <= SINE_TAB[ph_idx];
            cs_reg <= SINE_TAB[ph_idx + QUARTER];
        end
        if (state_reg == ST_FOLD)
        begin
            case (op_reg)
                OP_T:  t_reg  <= back_reg ? (ttime_reg - prod[47:0]) : prod[47:0];
                OP_W:  w_reg  <= prod[47:0];
                OP_P0: ph_reg <= prod[47:0];
                OP_P1: ph_reg <= ph_reg + {prod[31:0], 16'b0};
                OP_P2: ph_reg <= ph_reg + {prod[15:0], 32'b0};
                OP_C0: acc_reg <= prod64 + 64'sd4194304;
                OP_C1: wc_reg <= fold_c[63:23];
                OP_S0: acc_reg <= prod64 + 64'sd4194304;
                OP_S1: ws_reg <= fold_c[63:23];
                OP_VL: acc_reg <= prod64 + 64'sd128;
                OP_VH: inc_reg[j_reg] <= fold_v[63:8];
                default: ;
            endcase
        end
        if ((state_reg == ST_RESP) && (state_next == ST_IDLE))
            m_tdata_reg <= ok_reg ? rdata_reg : '0;
    end

    // Saturating update of the six sums
    logic [OUT_DATA_W-1:0] upd_word;

    always_comb
    begin
        logic [47:0]        old_sum;
        logic signed [57:0] sum;
        for (int k = 0; k < 6; k++)
        begin
            old_sum = rdata_reg[k*SUM_W +: SUM_W];
            sum     = $signed({{10{old_sum[47]}}, old_sum})
                      + $signed({{2{inc_reg[k][55]}}, inc_reg[k]});
            if (sum[57:47] != {11{sum[57]}})
                upd_word[k*SUM_W +: SUM_W] = sum[57] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            else
                upd_word[k*SUM_W +: SUM_W] = sum[47:0];
        end
    end

    // Accumulator store: one write and one registered read port
    logic [OUT_DATA_W-1:0] mem [DEPTH];
    logic                  mem_we;
    logic                  mem_re;
    logic [OUT_DATA_W-1:0] mem_wdata;

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign mem_re    = (state_reg == ST_TRIG) || ((state_reg == ST_READ) && ok_reg);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : upd_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rdata_reg <= mem[addr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("accumulator store written while idle");

    a_rise_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_RESP))
        else $error("result raised without a read request");

    a_freq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (3'(l_reg) < nf_reg))
        else $error("frequency counter beyond active count");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result changed before it was taken");

endmodule

`default_nettype wire
